// ===== src/fqk_pkg.sv =====
// shared widths, command codes and status codes for the keyed-removal queue
package fqk_pkg;

  localparam int CMD_W   = 3;
  localparam int ID_W    = 16;
  localparam int STAMP_W = 64;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_SIZE   = 3'd3,
    CMD_PEEK   = 3'd4,
    CMD_LOOKUP = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ===== src/fifo_queue_with_keyed_removal_top.sv =====
// keyed-removal queue: request decode, scan sequencer and shared id compare
// enqueue, size, unused codes and empty-queue errors finish from idle; peek and dequeue
//   read the head, lookup and remove scan from the newest entry
// one request at a time, busy stays high while a request runs
// rst (synchronous, active high) empties the queue; stored entries are not cleared
// the result strobe done is high for one cycle and cannot be stalled
module fifo_queue_with_keyed_removal_top #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fqk_pkg::CMD_W-1:0]   command,
  input  logic [fqk_pkg::ID_W-1:0]    item_id,
  input  logic [fqk_pkg::STAMP_W-1:0] arrival_stamp,
  output logic                        done,
  output logic [fqk_pkg::STAT_W-1:0]  status,
  output logic [fqk_pkg::ID_W-1:0]    out_id,
  output logic [fqk_pkg::STAMP_W-1:0] out_arrival,
  output logic [fqk_pkg::OCC_W-1:0]   occupancy
);

  localparam int AddrW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  // only the low ID_BITS of the id field take part in compares
  localparam int IdW   = (ID_BITS < fqk_pkg::ID_W) ? ID_BITS : fqk_pkg::ID_W;
  localparam int IdFW  = fqk_pkg::ID_W;
  localparam int StW   = fqk_pkg::STAMP_W;
  localparam int OccW  = fqk_pkg::OCC_W;
  localparam int EntW  = IdW + StW;
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,    // read data holds the oldest entry
    S_SEARCH,  // newest-to-oldest scan, read data holds entry ptr
    S_SHIFT    // gap closing, read data holds entry ptr+1, written to ptr
  } state_t;

  state_t            state;
  fqk_pkg::cmd_t     cmd_r;
  logic [IdW-1:0]    id_r;
  logic [CntW-1:0]   count;
  logic [AddrW-1:0]  ptr;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntW-1:0]   mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [EntW-1:0]   mem_rdata;

  logic [IdW-1:0]    rd_id;
  logic              rd_match;

  assign busy = (state != S_IDLE);

  // the one shared compare unit: stored id against the requested id
  assign rd_id    = mem_rdata[EntW-1:StW];
  assign rd_match = (rd_id == id_r);

  fqk_ram #(
    .WIDTH(EntW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // ram port steering; read data is registered, so each read is issued the cycle before its use
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        // enqueue writes at the tail
        mem_waddr = AddrW'(count);
        mem_wdata = {item_id[IdW-1:0], arrival_stamp};
        mem_we    = start && (command == fqk_pkg::CMD_ENQ) && (count != Full);
        // the scan starts at the newest entry, head commands read the oldest
        if ((command == fqk_pkg::CMD_DEQ) || (command == fqk_pkg::CMD_PEEK)) begin
          mem_raddr = '0;
        end else begin
          mem_raddr = AddrW'(count - CntW'(1));
        end
      end
      S_HEAD: begin
        mem_raddr = AddrW'(1);
      end
      S_SEARCH: begin
        // on a match the gap closing needs the entry above it next
        mem_raddr = rd_match ? (ptr + AddrW'(1)) : (ptr - AddrW'(1));
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_raddr = ptr + AddrW'(2);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // sequencer with the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r       <= fqk_pkg::cmd_t'(command);
            id_r        <= item_id[IdW-1:0];
            out_id      <= '0;
            out_arrival <= '0;
            ptr         <= AddrW'(count - CntW'(1));
            unique case (command)
              fqk_pkg::CMD_ENQ: begin
                done <= 1'b1;
                if (count == Full) begin
                  status    <= fqk_pkg::ST_FULL;
                  occupancy <= OccW'(count);
                end else begin
                  status    <= fqk_pkg::ST_OK;
                  count     <= count + CntW'(1);
                  occupancy <= OccW'(count + CntW'(1));
                end
              end
              fqk_pkg::CMD_DEQ, fqk_pkg::CMD_PEEK: begin
                if (count == '0) begin
                  done      <= 1'b1;
                  status    <= fqk_pkg::ST_EMPTY;
                  occupancy <= OccW'(count);
                end else begin
                  state <= S_HEAD;
                end
              end
              fqk_pkg::CMD_REMOVE, fqk_pkg::CMD_LOOKUP: begin
                if (count == '0) begin
                  done      <= 1'b1;
                  status    <= fqk_pkg::ST_EMPTY;
                  occupancy <= OccW'(count);
                end else begin
                  state <= S_SEARCH;
                end
              end
              default: begin
                // size and unused codes just report the count
                done      <= 1'b1;
                status    <= fqk_pkg::ST_OK;
                occupancy <= OccW'(count);
              end
            endcase
          end
        end
        S_HEAD: begin
          out_id <= IdFW'(rd_id);
          if ((cmd_r == fqk_pkg::CMD_PEEK) || (count == CntW'(1))) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= fqk_pkg::ST_OK;
            if (cmd_r == fqk_pkg::CMD_PEEK) begin
              occupancy <= OccW'(count);
            end else begin
              count     <= count - CntW'(1);
              occupancy <= OccW'(count - CntW'(1));
            end
          end else begin
            // dequeue with newer entries: slide them all down one place
            ptr   <= '0;
            state <= S_SHIFT;
          end
        end
        S_SEARCH: begin
          if (rd_match) begin
            if (cmd_r == fqk_pkg::CMD_LOOKUP) begin
              state       <= S_IDLE;
              done        <= 1'b1;
              status      <= fqk_pkg::ST_OK;
              out_arrival <= mem_rdata[StW-1:0];
              occupancy   <= OccW'(count);
            end else if ((CntW'(ptr) + CntW'(1)) == count) begin
              // newest entry matched, nothing to move
              state     <= S_IDLE;
              done      <= 1'b1;
              status    <= fqk_pkg::ST_OK;
              count     <= count - CntW'(1);
              occupancy <= OccW'(count - CntW'(1));
            end else begin
              state <= S_SHIFT;
            end
          end else if (ptr == '0) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            status    <= fqk_pkg::ST_NOT_FOUND;
            occupancy <= OccW'(count);
          end else begin
            ptr <= ptr - AddrW'(1);
          end
        end
        S_SHIFT: begin
          if ((CntW'(ptr) + CntW'(2)) == count) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            status    <= fqk_pkg::ST_OK;
            count     <= count - CntW'(1);
            occupancy <= OccW'(count - CntW'(1));
          end else begin
            ptr <= ptr + AddrW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the entry count never passes the queue depth
  assert property (@(posedge clk) disable iff (rst) count <= Full)
    else $error("entry count above queue depth");

  // a result is only presented once the sequencer is back at rest
  assert property (@(posedge clk) disable iff (rst) done |-> (state == S_IDLE))
    else $error("result strobe while a request is still running");

  // an enqueue into a queue with room grows it by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == fqk_pkg::CMD_ENQ) && (count != Full))
      |=> (count == ($past(count) + CntW'(1))))
    else $error("enqueue did not grow the queue by one");

  // a full status always reports a full queue
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == fqk_pkg::ST_FULL)) |-> (occupancy == OccW'(Full)))
    else $error("full status with a queue that is not full");

endmodule

// ===== src/fqk_ram.sv =====
// entry store: one write port, one read port with registered read data
module fqk_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
